// ===== hw/rtl/rctf_pkg.sv =====
// shared types and codes of the textured wall column renderer
// no dependencies; used by raycast_column_texture_fill
package rctf_pkg;

   localparam int FOLD_MOD    = 255;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [1:0] {
      KIND_RENDER = 2'd0,
      KIND_TEXEL  = 2'd1,
      KIND_SKY    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REGION_SKY   = 2'd0,
      REGION_WALL  = 2'd1,
      REGION_FLOOR = 2'd2
   } region_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SKY_OFFSET  = 2'd0,
      CSR_SKY_GAIN    = 2'd1,
      CSR_FLOOR_PIXEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [8:0]        row;
      logic [10:0]       column;
      logic [9:0]        wall_start;
      logic [9:0]        wall_stop;
      logic [31:0]       wall_distance;
      logic [2:0]        texture_index;
      logic signed [9:0] texel_x;
      logic [7:0]        texel_y;
      logic [31:0]       write_value;
   } item_type;

   typedef struct packed {
      logic [8:0]  row;
      logic [10:0] column;
      logic [31:0] pixel;
      region_type  region;
   } rsp_type;

endpackage

// ===== hw/rtl/rctf_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with a side tag
// uses no package; all stages advance together on the advance enable
module rctf_divider #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   logic          v_ff   [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [TW-1:0] tag_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_src;
      logic [DW-1:0] rem_src, den_src;
      logic [NW-1:0] num_src, quo_src;
      logic [TW-1:0] tag_src;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = '0;
         assign den_src = in_den;
         assign num_src = in_num;
         assign quo_src = '0;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign num_src = num_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      // partial remainder stays below the divisor, so DW bits hold it
      always_comb begin
         trial  = {rem_src, num_src[NW-1]};
         ge     = trial >= {1'b0, den_src};
         rem_in = ge ? DW'(trial - {1'b0, den_src}) : DW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_src;
         end
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            num_ff[k] <= num_src << 1;
            quo_ff[k] <= {quo_src[NW-2:0], ge};
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

// ===== hw/rtl/raycast_column_texture_fill.sv =====
// textured wall column renderer: sky, wall texel or floor color per screen pixel
// depends on rctf_pkg and rctf_divider
//
// Usage: req_ carries one word per item, its kind in req_tuser. Texel and sky
// load words write the texture and sky memories and give no result. A render
// word gives one rsp_ word (row, column, pixel, region in rsp_tuser) when its
// row and column lie inside the frame. Words leave in the order they came.
// One word is taken per clock while req_tready is high. A render result passes
// the input stage, the sky fold and sky address stages, the two bit-per-stage
// dividers (line height, then texture row) with the row numerator stages
// between them, the memory stage and its read, and the output register. Loads
// take effect at the memory stage, in order with renders.
// Reset clears all valid flags and sets sky offset 0, gain 1, floor color 0;
// the memories are not cleared and must be loaded before they are read.
// When rsp_tready is low the output register holds its word and one more
// result goes to a skid register; while that is full the whole pipeline,
// and with it req_tready, holds. csr_we writes the register named by csr_index.
module raycast_column_texture_fill #(
   parameter int FRAME_H   = 512,
   parameter int SKY_W     = 2048,
   parameter int TEX_H     = 256,
   parameter int TEX_COUNT = 8,
   parameter int FRAME_W   = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // kind
   input  logic [1:0]                      req_tuser,
   // row, column, wall_start, wall_stop, wall_distance, texture_index,
   // texel_x, texel_y, write_value, zero fill
   input  logic [127:0]                    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // region
   output logic [1:0]                      rsp_tuser,
   // out_row, out_column, pixel, zero fill
   output logic [55:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [rctf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int N1W   = $clog2(FRAME_H + 1) + 16;
   localparam int DLW   = N1W + 9;
   localparam int P2W   = DLW + 9;
   localparam int YW    = P2W - 8;
   localparam int NB    = (YW + 7) / 8;
   localparam int AW    = 24;
   localparam int CW    = $clog2(SKY_W);
   localparam int D_SKY = SKY_W - 1;
   localparam int SH_S  = AW + CW;
   localparam int MW    = AW + 2;
   localparam int SAW   = $clog2(FRAME_H * SKY_W);
   localparam int TAW   = $clog2(TEX_COUNT * 65536);
   localparam int TIW   = (TEX_COUNT > 1) ? $clog2(TEX_COUNT) : 1;
   localparam logic [N1W-1:0] NUM1  = N1W'(FRAME_H * 65536);
   localparam logic [MW-1:0]  M_SKY = MW'((64'd1 << SH_S) / 64'(D_SKY));

   typedef struct packed {
      rctf_pkg::item_type item;
      logic signed [24:0] gs;
   } st2_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [AW-1:0]      a;
      logic               need;
   } st3_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [AW-1:0]      a;
      logic               need;
      logic [AW+MW-1:0]   p;
   } st4_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [AW-1:0]      a;
      logic               need;
      logic [AW-1:0]      qd;
   } st5_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [CW-1:0]      col;
   } st6_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [SAW-1:0]     sky_addr;
   } tag1_type;

   typedef struct packed {
      tag1_type             t;
      logic [N1W-1:0]       h;
      logic signed [DLW-1:0] d;
   } st8_type;

   typedef struct packed {
      tag1_type              t;
      logic [N1W-1:0]        h;
      logic signed [P2W-1:0] p2;
   } st9_type;

   typedef struct packed {
      tag1_type       t;
      logic [N1W-1:0] h;
      logic           neg;
      logic [P2W-1:0] mag;
   } st10_type;

   typedef struct packed {
      rctf_pkg::item_type item;
      logic [SAW-1:0]     sky_addr;
      logic               neg;
   } tag2_type;

   typedef struct packed {
      logic [TAW-1:0]         tex_addr;
      logic [SAW-1:0]         sky_addr;
      logic                   tex_we;
      logic                   sky_we;
      logic [31:0]            value;
      logic                   emit;
      rctf_pkg::region_type   region;
      logic [8:0]             row;
      logic [10:0]            column;
   } st12_type;

   typedef struct packed {
      logic                 emit;
      rctf_pkg::region_type region;
      logic [8:0]           row;
      logic [10:0]          column;
   } st13_type;

   function automatic logic [7:0] fold_255(input logic [YW-1:0] v);
      logic [8*NB+7:0] pad;
      logic [11:0]     s;
      pad = (8 * NB + 8)'(v);
      s   = '0;
      // 256 is 1 modulo 255, so the byte sum keeps the residue
      for (int i = 0; i < NB; i++) begin
         s = s + 12'(pad[8*i +: 8]);
      end
      for (int i = 0; i < NB; i++) begin
         if (s >= 12'(rctf_pkg::FOLD_MOD)) begin
            s = s - 12'(rctf_pkg::FOLD_MOD);
         end
      end
      return 8'(s);
   endfunction

   function automatic logic [TIW-1:0] tex_mod(input logic [2:0] t);
      logic [3:0] v;
      v = {1'b0, t};
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= TEX_COUNT) begin
            v = v - 4'(TEX_COUNT);
         end
      end
      return TIW'(v);
   endfunction

   // configuration
   logic signed [15:0] sky_offset_ff;
   logic [7:0]         sky_gain_ff;
   logic [31:0]        floor_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sky_offset_ff  <= '0;
         sky_gain_ff    <= 8'd1;
         floor_pixel_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rctf_pkg::CSR_SKY_OFFSET:  sky_offset_ff  <= csr_wdata[15:0];
            rctf_pkg::CSR_SKY_GAIN:    sky_gain_ff    <= csr_wdata[7:0];
            rctf_pkg::CSR_FLOOR_PIXEL: floor_pixel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic skid_valid_ff;
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // stage 1: input word
   rctf_pkg::item_type s1_in, s1_ff;
   logic s1_valid_ff;

   always_comb begin
      s1_in.kind          = req_tuser;
      s1_in.row           = req_tdata[8:0];
      s1_in.column        = req_tdata[19:9];
      s1_in.wall_start    = req_tdata[29:20];
      s1_in.wall_stop     = req_tdata[39:30];
      s1_in.wall_distance = req_tdata[71:40];
      s1_in.texture_index = req_tdata[74:72];
      s1_in.texel_x       = req_tdata[84:75];
      s1_in.texel_y       = req_tdata[92:85];
      s1_in.write_value   = req_tdata[124:93];
   end

   // stages 2..7: sky column fold and sky address
   st2_type s2_in, s2_ff;
   st3_type s3_in, s3_ff;
   st4_type s4_in, s4_ff;
   st5_type s5_in, s5_ff;
   st6_type s6_in, s6_ff;
   tag1_type s7_in, s7_ff;
   logic s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff;

   logic signed [25:0] sky_c;
   logic [AW-1:0]      q_sky, r_sky;
   logic [31:0]        col_sel;

   always_comb begin
      s2_in.item = s1_ff;
      s2_in.gs   = 25'($signed({1'b0, sky_gain_ff}) * sky_offset_ff);

      sky_c      = $signed({15'd0, s2_ff.item.column}) + 26'(s2_ff.gs);
      s3_in.item = s2_ff.item;
      s3_in.a    = (sky_c < 0) ? AW'(-sky_c) : AW'(sky_c);
      s3_in.need = (sky_c < 0) || (sky_c > $signed(26'(D_SKY)));

      s4_in.item = s3_ff.item;
      s4_in.a    = s3_ff.a;
      s4_in.need = s3_ff.need;
      s4_in.p    = (AW + MW)'(s3_ff.a) * (AW + MW)'(M_SKY);

      // reciprocal estimate is exact or one low
      q_sky      = AW'(s4_ff.p >> SH_S);
      s5_in.item = s4_ff.item;
      s5_in.a    = s4_ff.a;
      s5_in.need = s4_ff.need;
      s5_in.qd   = AW'((AW + CW)'(q_sky) * (AW + CW)'(D_SKY));

      r_sky      = s5_ff.a - s5_ff.qd;
      s6_in.item = s5_ff.item;
      if (s5_ff.need) begin
         s6_in.col = (r_sky >= AW'(D_SKY)) ? CW'(r_sky - AW'(D_SKY)) : CW'(r_sky);
      end else begin
         s6_in.col = CW'(s5_ff.a);
      end

      col_sel = (s6_ff.item.kind == rctf_pkg::KIND_SKY) ? 32'(s6_ff.item.column)
                                                         : 32'(s6_ff.col);
      s7_in.item     = s6_ff.item;
      s7_in.sky_addr = SAW'(32'(s6_ff.item.row) * SKY_W + col_sel);
   end

   // line height divider
   logic     d1_valid;
   logic [N1W-1:0] d1_quo;
   tag1_type d1_tag;
   logic [31:0] dist_nz;

   assign dist_nz = (s7_ff.item.wall_distance == '0) ? 32'd1 : s7_ff.item.wall_distance;

   rctf_divider #(.NW(N1W), .DW(32), .TW($bits(tag1_type))) u_height_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (s7_valid_ff),
      .in_num    (NUM1),
      .in_den    (dist_nz),
      .in_tag    (s7_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag)
   );

   // stages 8..10: texture row numerator
   st8_type  s8_in, s8_ff;
   st9_type  s9_in, s9_ff;
   st10_type s10_in, s10_ff;
   logic s8_valid_ff, s9_valid_ff, s10_valid_ff;
   logic [N1W-1:0] h_clamp;
   logic signed [P2W-1:0] d_ext, th_ext;

   always_comb begin
      h_clamp  = (d1_quo == '0) ? N1W'(1) : d1_quo;
      s8_in.t  = d1_tag;
      s8_in.h  = h_clamp;
      s8_in.d  = $signed(DLW'({d1_tag.item.row, 8'd0})) - $signed(DLW'(FRAME_H * 128))
               + $signed(DLW'({h_clamp, 7'd0}));

      d_ext    = P2W'(s8_ff.d);
      th_ext   = P2W'(TEX_H);
      s9_in.t  = s8_ff.t;
      s9_in.h  = s8_ff.h;
      s9_in.p2 = d_ext * th_ext;

      s10_in.t   = s9_ff.t;
      s10_in.h   = s9_ff.h;
      s10_in.neg = s9_ff.p2 < 0;
      s10_in.mag = (s9_ff.p2 < 0) ? P2W'(-s9_ff.p2) : P2W'(s9_ff.p2);
   end

   // texture row divider, on magnitudes
   logic     d2_valid;
   logic [P2W-1:0] d2_quo;
   tag2_type d2_tag_in, d2_tag;

   assign d2_tag_in = '{item: s10_ff.t.item, sky_addr: s10_ff.t.sky_addr, neg: s10_ff.neg};

   rctf_divider #(.NW(P2W), .DW(N1W), .TW($bits(tag2_type))) u_texrow_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (s10_valid_ff),
      .in_num    (s10_ff.mag),
      .in_den    (s10_ff.h),
      .in_tag    (d2_tag_in),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_tag   (d2_tag)
   );

   // stage 12: memory operation
   st12_type s12_in, s12_ff;
   logic s12_valid_ff;
   logic [7:0] tex_y, tex_x;
   logic [TIW-1:0] tex_sel;
   rctf_pkg::item_type it;

   always_comb begin
      it      = d2_tag.item;
      tex_y   = d2_tag.neg ? 8'd0 : fold_255(d2_quo[P2W-1:8]);
      if (it.texel_x < 0) begin
         tex_x = 8'd0;
      end else if (it.texel_x >= 10'sd510) begin
         tex_x = 8'(it.texel_x - 10'sd510);
      end else if (it.texel_x >= 10'sd255) begin
         tex_x = 8'(it.texel_x - 10'sd255);
      end else begin
         tex_x = 8'(it.texel_x);
      end
      tex_sel = tex_mod(it.texture_index);

      s12_in.sky_addr = d2_tag.sky_addr;
      s12_in.value    = it.write_value;
      s12_in.row      = it.row;
      s12_in.column   = it.column;
      s12_in.tex_we   = 1'b0;
      s12_in.sky_we   = 1'b0;
      s12_in.emit     = 1'b0;
      s12_in.tex_addr = TAW'({tex_sel, tex_y, tex_x});
      case (it.kind)
         rctf_pkg::KIND_RENDER: begin
            s12_in.emit = (32'(it.row) < FRAME_H) && (32'(it.column) < FRAME_W);
         end
         rctf_pkg::KIND_TEXEL: begin
            s12_in.tex_we   = !it.texel_x[9];
            s12_in.tex_addr = TAW'({tex_sel, it.texel_y, it.texel_x[7:0]});
         end
         rctf_pkg::KIND_SKY: begin
            s12_in.sky_we = (32'(it.row) < FRAME_H) && (32'(it.column) < SKY_W);
         end
         default: ;
      endcase
      if ({1'b0, it.row} < it.wall_start) begin
         s12_in.region = rctf_pkg::REGION_SKY;
      end else if ({1'b0, it.row} < it.wall_stop) begin
         s12_in.region = rctf_pkg::REGION_WALL;
      end else begin
         s12_in.region = rctf_pkg::REGION_FLOOR;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= d1_valid;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s12_valid_ff <= d2_valid;
      end
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s12_ff <= s12_in;
      end
   end

   // memories: loads and reads share one stage, so order is kept
   logic [31:0] tex_mem [TEX_COUNT * 65536];
   logic [31:0] sky_mem [FRAME_H * SKY_W];
   logic [31:0] tex_rd_ff, sky_rd_ff;
   st13_type s13_ff;
   logic s13_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tex_rd_ff <= tex_mem[s12_ff.tex_addr];
         if (s12_valid_ff && s12_ff.tex_we) begin
            tex_mem[s12_ff.tex_addr] <= s12_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sky_rd_ff <= sky_mem[s12_ff.sky_addr];
         if (s12_valid_ff && s12_ff.sky_we) begin
            sky_mem[s12_ff.sky_addr] <= s12_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_valid_ff <= 1'b0;
      end else if (adv) begin
         s13_valid_ff <= s12_valid_ff;
      end
      if (adv) begin
         s13_ff <= '{emit: s12_ff.emit, region: s12_ff.region,
                     row: s12_ff.row, column: s12_ff.column};
      end
   end

   // output register with one skid word
   rctf_pkg::rsp_type res_in, out_ff, skid_ff;
   logic out_valid_ff, push, pop;

   always_comb begin
      res_in.row    = s13_ff.row;
      res_in.column = s13_ff.column;
      res_in.region = s13_ff.region;
      case (s13_ff.region)
         rctf_pkg::REGION_SKY:  res_in.pixel = sky_rd_ff;
         rctf_pkg::REGION_WALL: res_in.pixel = tex_rd_ff;
         default:               res_in.pixel = floor_pixel_ff;
      endcase
   end

   assign push = adv && s13_valid_ff && s13_ff.emit;
   assign pop  = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= res_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.region;
   assign rsp_tdata  = {4'd0, out_ff.pixel, out_ff.column, out_ff.row};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("stalled result not caught by skid register");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> !skid_valid_ff && out_valid_ff)
      else $error("skid word not moved to output");

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rctf_pkg::REGION_SKY ||
                      rsp_tuser == rctf_pkg::REGION_WALL ||
                      rsp_tuser == rctf_pkg::REGION_FLOOR))
      else $error("result carries an unused region code");

endmodule
